### rtl/core/assert_macros.svh
// Shared assertion macros for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/core/sact_pkg.sv
package sact_pkg;

  // Counter and configuration port widths
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 4'd3;

  // Register reset values
  localparam logic       POLICY_RST = 1'b0;
  localparam logic [4:0] OFFSET_RST = 5'd2;
  localparam logic [2:0] SETB_RST   = 3'd0;
  localparam logic [3:0] WAYS_RST   = 4'd1;

  // Field codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_WRITE  = 1'b1;

endpackage

### rtl/core/sact_ram.sv
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/set_assoc_cache_tag_sim.sv
// Set-associative cache tag model with FIFO or LRU replacement. Each input item is one access
// (tuser = kind, tdata = byte address); each gives one result item carrying hit, fill-read and
// write flags plus the running hit, miss, memory-read and memory-write counts. All ways of a
// set live in one row of a tag RAM with a registered read, so an item has a read step for the
// set's row and a compare step that checks the ways in use, picks the victim and, on a miss or
// an LRU hit, writes the row back. A result not yet taken holds the block in the compare step,
// while one finished result waits in the output register. After reset a clearing pass writes
// every row of the tag RAM, one row a cycle; no item is accepted before it ends, while
// configuration writes are taken at any time. Lines are not flushed when the geometry changes.
`include "assert_macros.svh"

module set_assoc_cache_tag_sim #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_BITS  = 48,
  parameter int STAMP_BITS = 32,
  localparam int IN_DW     = ((ADDR_BITS + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // access input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_DW-1:0]                s_axis_tdata,  // address
  input  logic                            s_axis_tuser,  // kind
  // result output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [4*sact_pkg::CNT_W-1:0]    m_axis_tdata,  // hit_total, miss_total,
                                                         // read_total, write_total
  output logic [2:0]                      m_axis_tuser   // hit, mem_read, mem_write
);

  import sact_pkg::*;

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W  = 1 + ADDR_BITS + STAMP_BITS;
  localparam int ROW_W   = MAX_WAYS * LINE_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_LOOK  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [SET_W-1:0]      clr_q, clr_d;

  logic                  policy_q;
  logic [4:0]            off_q;
  logic [2:0]            setb_q;
  logic [3:0]            ways_q;

  logic [SET_W-1:0]      set_q;
  logic [ADDR_BITS-1:0]  tag_q;
  logic                  kind_q;
  logic [STAMP_BITS-1:0] clk_cnt_q;
  logic [CNT_W-1:0]      hits_q, misses_q, reads_q, writes_q;
  logic                  m_valid_q;
  logic [2:0]            out_user_q;

  logic                  s_fire, lk_done;
  logic [ADDR_BITS-1:0]  addr_c, blk_c, tag_c;
  logic [2:0]            sb_eff;
  logic [SET_W-1:0]      set_mask, set_c;

  logic                  ram_we;
  logic [SET_W-1:0]      ram_waddr;
  logic [ROW_W-1:0]      ram_wdata, ram_rdata;

  logic                  w_valid   [MAX_WAYS];
  logic [ADDR_BITS-1:0]  w_tag     [MAX_WAYS];
  logic [STAMP_BITS-1:0] w_stamp   [MAX_WAYS];
  logic                  w_search  [MAX_WAYS];
  logic                  t_ok      [MAX_WAYS];
  logic [STAMP_BITS-1:0] t_st      [MAX_WAYS];
  logic [WAY_W-1:0]      t_ix      [MAX_WAYS];

  logic                  hit_c, any_inv;
  logic [WAY_W-1:0]      hit_idx, inv_idx, vic_idx, sel_idx;
  logic [ROW_W-1:0]      wrow_c;
  logic [CNT_W-1:0]      tot_c;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign lk_done       = (state_q == S_LOOK) && (!m_valid_q || m_axis_tready);

  // Address split: drop offset, low bits pick the set, the rest is the tag
  assign sb_eff   = (int'(setb_q) > SET_LOG) ? 3'(SET_LOG) : setb_q;
  assign addr_c   = s_axis_tdata[ADDR_BITS-1:0];
  assign blk_c    = addr_c >> off_q;
  assign set_mask = ~({SET_W{1'b1}} << sb_eff);
  assign set_c    = blk_c[SET_W-1:0] & set_mask;
  assign tag_c    = blk_c >> sb_eff;

  // Unpack the row read for this access
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      w_stamp[w]  = ram_rdata[w*LINE_W +: STAMP_BITS];
      w_tag[w]    = ram_rdata[w*LINE_W + STAMP_BITS +: ADDR_BITS];
      w_valid[w]  = ram_rdata[w*LINE_W + LINE_W - 1];
      w_search[w] = (w == 0) || (w < int'(ways_q));
    end
  end

  // Tag match (lowest way wins) and highest invalid way
  always_comb begin
    hit_c   = 1'b0;
    hit_idx = '0;
    any_inv = 1'b0;
    inv_idx = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (w_search[w] && w_valid[w] && (w_tag[w] == tag_q)) begin
        hit_c   = 1'b1;
        hit_idx = WAY_W'(w);
      end
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (w_search[w] && !w_valid[w]) begin
        any_inv = 1'b1;
        inv_idx = WAY_W'(w);
      end
    end
  end

  // Oldest-stamp tree; ties keep the lower way
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      t_ok[w] = w_search[w];
      t_st[w] = w_stamp[w];
      t_ix[w] = WAY_W'(w);
    end
    for (int s = 1; s < MAX_WAYS; s = s * 2) begin
      for (int i = 0; i + s < MAX_WAYS; i = i + 2 * s) begin
        if (t_ok[i+s] && (!t_ok[i] || (t_st[i+s] < t_st[i]))) begin
          t_ok[i] = 1'b1;
          t_st[i] = t_st[i+s];
          t_ix[i] = t_ix[i+s];
        end
      end
    end
  end

  assign vic_idx = any_inv ? inv_idx : t_ix[0];
  assign sel_idx = hit_c ? hit_idx : vic_idx;

  // Row write-back: refreshed or filled line in the chosen way
  always_comb begin
    wrow_c = ram_rdata;
    wrow_c[sel_idx*LINE_W +: LINE_W] = {1'b1, tag_q, clk_cnt_q};
  end

  assign ram_we    = (state_q == S_CLEAR) ||
                     (lk_done && (!hit_c || (policy_q == POLICY_LRU)));
  assign ram_waddr = (state_q == S_CLEAR) ? clr_q : set_q;
  assign ram_wdata = (state_q == S_CLEAR) ? '0 : wrow_c;

  sact_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s_fire),
    .raddr_i (set_c),
    .rdata_o (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_q == SET_W'(MAX_SETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_fire) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        if (lk_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RST;
      off_q    <= OFFSET_RST;
      setb_q   <= SETB_RST;
      ways_q   <= WAYS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POLICY:      policy_q <= cfg_data_i[0];
        CFG_OFFSET_BITS: off_q    <= cfg_data_i[4:0];
        CFG_SET_BITS:    setb_q   <= cfg_data_i[2:0];
        CFG_WAYS_IN_USE: ways_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Access captured at accept
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      set_q  <= set_c;
      tag_q  <= tag_c;
      kind_q <= s_axis_tuser;
    end
  end

  // Counters, access clock and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_cnt_q  <= '0;
      hits_q     <= '0;
      misses_q   <= '0;
      reads_q    <= '0;
      writes_q   <= '0;
      m_valid_q  <= 1'b0;
      out_user_q <= '0;
    end else begin
      if (lk_done) begin
        clk_cnt_q  <= clk_cnt_q + STAMP_BITS'(1);
        m_valid_q  <= 1'b1;
        out_user_q <= {kind_q == KIND_WRITE, !hit_c, hit_c};
        if (hit_c) begin
          hits_q   <= hits_q + CNT_W'(1);
        end else begin
          misses_q <= misses_q + CNT_W'(1);
          reads_q  <= reads_q + CNT_W'(1);
        end
        if (kind_q == KIND_WRITE) begin
          writes_q <= writes_q + CNT_W'(1);
        end
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Totals stay put while a result waits: the next result needs the register free
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tdata  = {writes_q, reads_q, misses_q, hits_q};

  assign tot_c = hits_q + misses_q;

  `AST_PROP(a_reads_match_misses, clk_i, rst_ni, reads_q == misses_q,
            "memory read count diverged from miss count")
  `AST_PROP(a_one_count_per_item, clk_i, rst_ni, lk_done |=> (tot_c == $past(tot_c) + CNT_W'(1)),
            "finished item did not add exactly one hit or miss")
  `AST_PROP(a_miss_fills_row, clk_i, rst_ni, (lk_done && !hit_c) |-> ram_we,
            "miss finished without a tag RAM fill")
  `AST_NEVER(a_hit_and_fill, clk_i, rst_ni, m_valid_q && (out_user_q[0] == out_user_q[1]),
             "result flags hit and mem_read not exclusive")

endmodule

### dv/tb_set_assoc_cache_tag_sim.sv
module tb_set_assoc_cache_tag_sim;
  import sact_pkg::*;

  localparam int MAX_SETS    = 64;
  localparam int MAX_WAYS    = 8;
  localparam int LINES       = MAX_SETS * MAX_WAYS;
  localparam int HOLD_CYCLES = 300;

  // One expected result item
  typedef struct packed {
    logic        hit;
    logic        fill;
    logic        wr;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] fills;
    logic [31:0] writes;
  } access_result_t;

  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_valid_i   = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i    = '0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [47:0]               s_axis_tdata  = '0;  // address
  logic                      s_axis_tuser  = 1'b0; // kind
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [4*CNT_W-1:0]        m_axis_tdata;  // hit_total, miss_total, read_total, write_total
  logic [2:0]                m_axis_tuser;  // hit, mem_read, mem_write

  set_assoc_cache_tag_sim u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predicted cache contents and counters
  logic        line_ok    [LINES];
  logic [47:0] line_tag_q [LINES];
  logic [31:0] line_age   [LINES];
  logic [31:0] tick;
  logic [31:0] n_hit, n_miss, n_fill, n_wr;

  // Predicted register values
  logic        cfg_policy;
  logic [4:0]  cfg_offset;
  logic [2:0]  cfg_setb;
  logic [3:0]  cfg_ways;

  access_result_t pending_results[$];
  int             mismatch_count = 0;
  int             result_count   = 0;
  int             src_idle_pct   = 0;
  int             sink_stall_pct = 0;
  logic           hold_req       = 1'b0;
  logic           hold_active    = 1'b0;

  initial begin : clock_gen
    forever #2 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Cache state after reset
  initial begin : predictor_init
    for (int i = 0; i < LINES; i++) begin
      line_ok[i]    = 1'b0;
      line_tag_q[i] = '0;
      line_age[i]   = '0;
    end
    tick       = '0;
    n_hit      = '0;
    n_miss     = '0;
    n_fill     = '0;
    n_wr       = '0;
    cfg_policy = POLICY_RST;
    cfg_offset = OFFSET_RST;
    cfg_setb   = SETB_RST;
    cfg_ways   = WAYS_RST;
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Lookup, victim choice and counter update for one access
  function automatic access_result_t predict_access(logic kind, logic [47:0] addr);
    access_result_t r;
    int             sb, ways, set_idx, base, victim, k;
    logic [47:0]    blk, tag;
    logic [31:0]    oldest;
    logic           found;
    sb = cfg_setb;
    while (sb > 0 && (1 << sb) > MAX_SETS) sb--;
    ways = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
    blk     = addr >> cfg_offset;
    set_idx = int'(blk & ((48'd1 << sb) - 48'd1));
    tag     = blk >> sb;
    base    = set_idx * MAX_WAYS;
    victim  = base;
    oldest  = line_age[base];
    found   = 1'b0;
    for (int i = 0; i < ways; i++) begin
      k = base + i;
      if (line_ok[k] && line_tag_q[k] == tag) begin
        found  = 1'b1;
        victim = k;
        break;
      end
      // invalid ways always win; among valid ones the strictly older
      if (!line_ok[k] || line_age[k] < oldest) begin
        victim = k;
        oldest = line_age[k];
      end
    end
    if (found) begin
      n_hit = n_hit + 1;
      if (cfg_policy == POLICY_LRU) line_age[victim] = tick;
    end else begin
      n_miss             = n_miss + 1;
      n_fill             = n_fill + 1;
      line_ok[victim]    = 1'b1;
      line_tag_q[victim] = tag;
      line_age[victim]   = tick;
    end
    if (kind == KIND_WRITE) n_wr = n_wr + 1;
    tick     = tick + 1;
    r.hit    = found;
    r.fill   = !found;
    r.wr     = (kind == KIND_WRITE);
    r.hits   = n_hit;
    r.misses = n_miss;
    r.fills  = n_fill;
    r.writes = n_wr;
    return r;
  endfunction

  // Offer one access, with random idle cycles before it
  task automatic send_access(input logic kind, input logic [47:0] addr);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= addr;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_access(kind, addr));
  endtask

  // Stop offering items and let every pending result come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_POLICY:      cfg_policy = data[0];
      CFG_OFFSET_BITS: cfg_offset = data[4:0];
      CFG_SET_BITS:    cfg_setb   = data[2:0];
      CFG_WAYS_IN_USE: cfg_ways   = data[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver ready, stalled at random or held off entirely
  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      m_axis_tready <= !hold_active && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Long receiver hold-off, counted here
  initial begin : sink_hold
    forever begin
      wait (hold_req);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
      hold_req = 1'b0;
    end
  end

  task automatic note_mismatch(input string field, input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("result %0d: %s expected %0h got %0h", result_count, field, want, got);
  endtask

  task automatic check_result();
    access_result_t want, got;
    got.hit    = m_axis_tuser[0];
    got.fill   = m_axis_tuser[1];
    got.wr     = m_axis_tuser[2];
    got.hits   = m_axis_tdata[31:0];
    got.misses = m_axis_tdata[63:32];
    got.fills  = m_axis_tdata[95:64];
    got.writes = m_axis_tdata[127:96];
    if (pending_results.size() == 0) begin
      note_mismatch("unexpected item", 32'd0, 32'd1);
    end else begin
      want = pending_results.pop_front();
      if (got.hit !== want.hit)       note_mismatch("hit", want.hit, got.hit);
      if (got.fill !== want.fill)     note_mismatch("mem_read", want.fill, got.fill);
      if (got.wr !== want.wr)         note_mismatch("mem_write", want.wr, got.wr);
      if (got.hits !== want.hits)     note_mismatch("hit_total", want.hits, got.hits);
      if (got.misses !== want.misses) note_mismatch("miss_total", want.misses, got.misses);
      if (got.fills !== want.fills)   note_mismatch("read_total", want.fills, got.fills);
      if (got.writes !== want.writes) note_mismatch("write_total", want.writes, got.writes);
    end
    result_count++;
  endtask

  initial begin : result_check
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result();
    end
  end

  // Default geometry: one way, one set; hit, hit by write, eviction
  task automatic test_reset_geometry();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    send_access(KIND_READ, 48'h0);
    send_access(KIND_READ, 48'h0);
    send_access(KIND_WRITE, 48'h3);
    send_access(KIND_READ, 48'hFFFF_FFFF_FFFF);
    send_access(KIND_WRITE, 48'h0);
  endtask

  // LRU, all eight ways, oversized set count; fill a set, refresh, evict
  task automatic test_lru_fill_evict();
    write_cfg(CFG_POLICY, 8'hFF);
    write_cfg(CFG_OFFSET_BITS, 8'h00);
    write_cfg(CFG_SET_BITS, 8'hFF);
    write_cfg(CFG_WAYS_IN_USE, 8'hFF);
    for (int t = 1; t <= 8; t++) send_access(KIND_READ, 48'(t) << 6);
    send_access(KIND_WRITE, 48'd1 << 6);
    send_access(KIND_READ, 48'd9 << 6);
    send_access(KIND_READ, 48'd1 << 6);
  endtask

  // FIFO, widest offset, zero ways, geometry change over stale tags
  task automatic test_extreme_geometry();
    write_cfg(CFG_POLICY, 8'h02);
    write_cfg(CFG_OFFSET_BITS, 8'hFF);
    write_cfg(CFG_WAYS_IN_USE, 8'h00);
    write_cfg(CFG_SET_BITS, 8'h03);
    send_access(KIND_WRITE, 48'hFFFF_FFFF_FFFF);
    send_access(KIND_READ, 48'h0);
    send_access(KIND_READ, 48'h0000_8000_0000);
    send_access(KIND_WRITE, 48'hFFFF_FFFF_FFFF);
  endtask

  // Receiver holds off while items keep coming, so the input stalls
  task automatic test_backpressure();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    for (int n = 0; n < 40; n++) send_access(1'($urandom), 48'($urandom_range(0, 15)) << 2);
  endtask

  // Random geometry per phase; mostly a working set of blocks, some wild addresses
  task automatic test_random_mix();
    int          off, pool_n;
    logic [47:0] pool [64];
    logic [47:0] addr, low_mask;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 9))
        0:       off = 0;
        1:       off = 31;
        2:       off = 16;
        default: off = $urandom_range(0, 6);
      endcase
      write_cfg(CFG_POLICY, 8'($urandom));
      write_cfg(CFG_OFFSET_BITS, {3'($urandom), 5'(off)});
      write_cfg(CFG_SET_BITS, {5'($urandom), 3'($urandom_range(0, 7))});
      write_cfg(CFG_WAYS_IN_USE, {4'($urandom), 4'($urandom_range(0, 15))});
      case (phase % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
        default: begin src_idle_pct = 29; sink_stall_pct = 29; end
      endcase
      pool_n   = $urandom_range(8, 64);
      low_mask = (48'd1 << off) - 48'd1;
      for (int i = 0; i < pool_n; i++)
        pool[i] = (48'($urandom_range(0, 2 * pool_n)) << off) | (rand48() & low_mask);
      for (int n = 0; n < 230; n++) begin
        if ($urandom_range(99) < 75)
          addr = pool[$urandom_range(0, pool_n - 1)] ^ (rand48() & low_mask);
        else
          addr = rand48();
        send_access(1'($urandom), addr);
      end
    end
  endtask

  initial begin : test_sequence
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_geometry();
    test_lru_fill_evict();
    test_extreme_geometry();
    test_backpressure();
    test_random_mix();
    drain_results();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
